// ===== design/discrete_frechet_distance_core_macros.svh =====
// Assertion macros for the discrete Frechet distance core.
// Used by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef DISCRETE_FRECHET_DISTANCE_CORE_MACROS_SVH
`define DISCRETE_FRECHET_DISTANCE_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define DFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dfd check failed");

// Consequent holds in the cycle after the antecedent.
`define DFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dfd check failed");

`endif

// ===== design/dfd_pkg.sv =====
// Shared types and codes for the discrete Frechet distance core.
// No dependencies.
package dfd_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DIST_W = 34;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_P  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_Q  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROP  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } dfd_eng_stat_t;

endpackage

// ===== design/dfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dfd_ram #(
  parameter int unsigned W     = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/dfd_engine.sv =====
// Coupling-table sequencer: walks all point pairs, keeps one rolling row in a RAM.
// Depends on dfd_pkg and dfd_ram; point RAMs live in the top level.
module dfd_engine import dfd_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned IW = $clog2(MAX_POINTS),
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned PW = 3 * COORD_BITS,
  localparam int unsigned DW = 2 * COORD_BITS + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CW-1:0] np_i,
  input  logic [CW-1:0] nq_i,
  output logic [IW-1:0] p_raddr_o,
  input  logic [PW-1:0] p_rdata_i,
  output logic [IW-1:0] q_raddr_o,
  input  logic [PW-1:0] q_rdata_i,
  output dfd_eng_stat_t stat_o,
  output logic [DW-1:0] result_o
);

  localparam int unsigned CB = COORD_BITS;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RDP  = 8'b0000_0010,
    ST_LDP  = 8'b0000_0100,
    ST_RD   = 8'b0000_1000,
    ST_SUB  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_ADD  = 8'b0100_0000,
    ST_UPD  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [CW-1:0] np_q, nq_q;
  logic [PW-1:0] p_q;
  logic signed [CB:0] dx_q, dy_q, dz_q;
  logic signed [2*CB+1:0] sx_q, sy_q, sz_q;
  logic [DW-1:0] d_q, up_q, diag_q, left_q, res_q, row_rdata;
  logic [DW-1:0] min3, cand, cell_val;
  logic done_q;
  logic last_col, last_row;

  dfd_ram #(.W(DW), .DEPTH(MAX_POINTS)) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_UPD),
    .waddr_i(j_q),
    .wdata_i(cell_val),
    .raddr_i(j_q),
    .rdata_o(row_rdata)
  );

  assign p_raddr_o = i_q;
  assign q_raddr_o = j_q;

  assign last_col = (CW'(j_q) + CW'(1)) == nq_q;
  assign last_row = (CW'(i_q) + CW'(1)) == np_q;

  always_comb begin
    min3 = (up_q < diag_q) ? up_q : diag_q;
    if (left_q < min3) min3 = left_q;
    if (i_q != '0 && j_q != '0) begin
      cand = min3;
    end else if (i_q != '0) begin
      cand = up_q;
    end else if (j_q != '0) begin
      cand = left_q;
    end else begin
      cand = d_q;
    end
    cell_val = (cand > d_q) ? cand : d_q;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    case (state_q)
      ST_IDLE: if (start_i) begin
        i_d = '0;
        j_d = '0;
        state_d = ST_RDP;
      end
      ST_RDP: state_d = ST_LDP;
      ST_LDP: state_d = ST_RD;
      ST_RD:  state_d = ST_SUB;
      ST_SUB: state_d = ST_MUL;
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_UPD;
      ST_UPD: begin
        if (!last_col) begin
          j_d = j_q + IW'(1);
          state_d = ST_RD;
        end else if (!last_row) begin
          i_d = i_q + IW'(1);
          j_d = '0;
          state_d = ST_RDP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      done_q  <= (state_q == ST_UPD) && last_col && last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      np_q <= np_i;
      nq_q <= nq_i;
    end
    if (state_q == ST_LDP) p_q <= p_rdata_i;
    if (state_q == ST_SUB) begin
      dx_q <= $signed({p_q[CB-1], p_q[CB-1:0]})
            - $signed({q_rdata_i[CB-1], q_rdata_i[CB-1:0]});
      dy_q <= $signed({p_q[2*CB-1], p_q[2*CB-1:CB]})
            - $signed({q_rdata_i[2*CB-1], q_rdata_i[2*CB-1:CB]});
      dz_q <= $signed({p_q[3*CB-1], p_q[3*CB-1:2*CB]})
            - $signed({q_rdata_i[3*CB-1], q_rdata_i[3*CB-1:2*CB]});
      up_q <= row_rdata;
    end
    if (state_q == ST_MUL) begin
      sx_q <= dx_q * dx_q;
      sy_q <= dy_q * dy_q;
      sz_q <= dz_q * dz_q;
    end
    if (state_q == ST_ADD) begin
      d_q <= DW'(sx_q) + DW'(sy_q) + DW'(sz_q);
    end
    if (state_q == ST_UPD) begin
      left_q <= cell_val;
      diag_q <= up_q;
      res_q  <= cell_val;
    end
  end

  assign stat_o.busy = (state_q != ST_IDLE) || done_q;
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule

// ===== design/discrete_frechet_distance_core.sv =====
// Discrete Frechet distance core.
// Channels: s_axis carries one item per handshake; tuser is the function
// (load first curve, load second curve, compute), tdata the point x, y, z.
// Loads give no result; a load beyond MAX_POINTS
// is dropped and flagged. A compute item gives one m_axis item: tdata the
// squared distance, tuser the status (ok, empty curve, points dropped).
// Compute with an empty curve answers in the next cycle. Otherwise the
// engine reads the second curve and the rolling row from their RAMs once
// per cell and the first curve once per row; each row first reads and loads
// its point, then each cell steps through read, sub, mul, add and update;
// the single shared read port of each RAM and this chain set the pace.
// No item is taken while a compute runs. After each compute both counts
// and the drop flag clear. Reset clears counts, flag and the output
// valid; RAM contents need no clearing. A stalled receiver holds the
// result in the output register and no item is taken while it waits; the
// next item can be taken in the cycle the receiver takes the result.
module discrete_frechet_distance_core import dfd_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x [CB-1:0], y, z, zero pad to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [FUNC_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // distance_sq [33:0], zero pad
  output logic [((DIST_W+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [STAT_W-1:0] m_axis_tuser
);

  `include "discrete_frechet_distance_core_macros.svh"

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = 3 * COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS + 2;
  localparam int unsigned OTW = ((DIST_W + 7) / 8) * 8;

  logic [CW-1:0] cnt_p_q, cnt_q_q;
  logic ovf_q, run_ovf_q;
  logic out_valid_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [STAT_W-1:0] out_stat_q;
  logic acc, acc_lp, acc_lq, acc_cmp, empty;
  logic p_full, q_full;
  logic [IW-1:0] p_raddr, q_raddr;
  logic [PW-1:0] p_rdata, q_rdata;
  dfd_eng_stat_t eng_stat;
  logic [DW-1:0] eng_res;
  logic [DW+DIST_W-1:0] res_ext;

  assign s_axis_tready = !eng_stat.busy && (!out_valid_q || m_axis_tready);
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign acc_lp  = acc && (s_axis_tuser == FUNC_LOAD_P);
  assign acc_lq  = acc && (s_axis_tuser == FUNC_LOAD_Q);
  assign acc_cmp = acc && (s_axis_tuser == FUNC_COMPUTE);
  assign p_full  = cnt_p_q == CW'(MAX_POINTS);
  assign q_full  = cnt_q_q == CW'(MAX_POINTS);
  assign empty   = (cnt_p_q == '0) || (cnt_q_q == '0);

  dfd_ram #(.W(PW), .DEPTH(MAX_POINTS)) u_p_ram (
    .clk_i  (clk_i),
    .we_i   (acc_lp && !p_full),
    .waddr_i(cnt_p_q[IW-1:0]),
    .wdata_i(s_axis_tdata[PW-1:0]),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  dfd_ram #(.W(PW), .DEPTH(MAX_POINTS)) u_q_ram (
    .clk_i  (clk_i),
    .we_i   (acc_lq && !q_full),
    .waddr_i(cnt_q_q[IW-1:0]),
    .wdata_i(s_axis_tdata[PW-1:0]),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  dfd_engine #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (acc_cmp && !empty),
    .np_i     (cnt_p_q),
    .nq_i     (cnt_q_q),
    .p_raddr_o(p_raddr),
    .p_rdata_i(p_rdata),
    .q_raddr_o(q_raddr),
    .q_rdata_i(q_rdata),
    .stat_o   (eng_stat),
    .result_o (eng_res)
  );

  assign res_ext = {{DIST_W{1'b0}}, eng_res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_p_q     <= '0;
      cnt_q_q     <= '0;
      ovf_q       <= 1'b0;
      run_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_cmp) begin
        cnt_p_q   <= '0;
        cnt_q_q   <= '0;
        ovf_q     <= 1'b0;
        run_ovf_q <= ovf_q;
      end else begin
        if (acc_lp) begin
          if (p_full) ovf_q <= 1'b1;
          else cnt_p_q <= cnt_p_q + CW'(1);
        end
        if (acc_lq) begin
          if (q_full) ovf_q <= 1'b1;
          else cnt_q_q <= cnt_q_q + CW'(1);
        end
      end
      if ((acc_cmp && empty) || eng_stat.done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_cmp && empty) begin
      out_dist_q <= '0;
      out_stat_q <= STAT_EMPTY;
    end else if (eng_stat.done) begin
      out_dist_q <= res_ext[DIST_W-1:0];
      out_stat_q <= run_ovf_q ? STAT_DROP : STAT_OK;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OTW'(out_dist_q);
  assign m_axis_tuser  = out_stat_q;

  // Engine finishes only into an empty output register.
  `DFD_ASSERT_NOW(a_done_out_free, eng_stat.done, !out_valid_q)
  // A compute on non-empty curves starts the engine.
  `DFD_ASSERT_NEXT(a_cmp_starts, acc_cmp && !empty, eng_stat.busy && !out_valid_q)
  // Counts stay within capacity.
  `DFD_ASSERT_NOW(a_cnt_range, 1'b1, (cnt_p_q <= CW'(MAX_POINTS)) && (cnt_q_q <= CW'(MAX_POINTS)))

endmodule
